/* hw/rtl/lcwv_pkg.sv */
// Shared types and constants for the Lab chroma-weighted vibrance pipeline.
`timescale 1ns / 1ps
`default_nettype none
package lcwv_pkg;

   localparam int StageCount        = 10;
   localparam int FrontStageCount   = 2;
   localparam int SqrtStageCount    = 4;
   localparam int SqrtStepsPerStage = 4;
   localparam int BoostStageCount   = 4;
   localparam int BoostFirst        = FrontStageCount + SqrtStageCount;
   localparam int PayloadDepth      = BoostFirst;

   // floor(x / 100) == (x * RecipMul) >> RecipShift for x < 2^23
   localparam int          RecipShift = 30;
   localparam logic [23:0] RecipMul   = 24'd10737419;
   localparam logic [22:0] RoundHalf  = 23'd50;

   localparam logic [1:0] ChanLumaA = 2'd2;
   localparam logic [1:0] ChanAll   = 2'd3;

   localparam logic CsrPercent  = 1'b0;
   localparam logic CsrChannels = 1'b1;

   localparam logic [6:0] PercentReset  = 7'd25;
   localparam logic [1:0] ChannelsReset = ChanAll;

   typedef struct packed {
      logic [14:0]        lightness;
      logic signed [15:0] chroma_a;
      logic signed [15:0] chroma_b;
      logic [15:0]        alpha;
      logic               last_pixel;
   } payload_type;

   typedef struct packed {
      logic [31:0] rad;
      logic [18:0] rem;
      logic [15:0] root;
   } sqrt_type;

endpackage
`default_nettype wire

/* hw/rtl/lcwv_pipe_ctrl.sv */
// Valid bits and per-stage load enables for the item pipeline.
`timescale 1ns / 1ps
`default_nettype none
module lcwv_pipe_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_stall,
   output logic                               out_valid,
   input  wire logic                          out_stall,
   output logic [lcwv_pkg::StageCount-1:0]    stage_en
);
   import lcwv_pkg::*;

   logic [StageCount-1:0] valid_ff;
   logic [StageCount-1:0] valid_in;

   always_comb begin
      logic ready;
      ready = !out_stall;
      for (int i = StageCount - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || ready;
         ready       = stage_en[i];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < StageCount; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_stall  = !stage_en[0];
   assign out_valid = valid_ff[StageCount-1];

endmodule
`default_nettype wire

/* hw/rtl/lcwv_front.sv */
// Chroma squares and their sum, two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module lcwv_front (
   input  wire logic               clock,
   input  wire logic [1:0]         stage_en,
   input  wire logic signed [15:0] chroma_a,
   input  wire logic signed [15:0] chroma_b,
   output logic [31:0]             sum_sq
);
   import lcwv_pkg::*;

   logic signed [31:0] asq_full;
   logic signed [31:0] bsq_full;
   logic [30:0]        asq_in;
   logic [30:0]        bsq_in;
   logic [30:0]        asq_ff;
   logic [30:0]        bsq_ff;
   logic [31:0]        sum_in;
   logic [31:0]        sum_ff;

   assign asq_full = chroma_a * chroma_a;
   assign bsq_full = chroma_b * chroma_b;
   assign asq_in   = asq_full[30:0];
   assign bsq_in   = bsq_full[30:0];
   assign sum_in   = {1'b0, asq_ff} + {1'b0, bsq_ff};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         asq_ff <= asq_in;
         bsq_ff <= bsq_in;
      end
      if (stage_en[1]) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_sq = sum_ff;

endmodule
`default_nettype wire

/* hw/rtl/lcwv_isqrt_stage.sv */
// One stage of the pipelined integer square root: several root bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module lcwv_isqrt_stage (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire lcwv_pkg::sqrt_type d,
   output lcwv_pkg::sqrt_type      q
);
   import lcwv_pkg::*;

   sqrt_type step_in;
   sqrt_type step_ff;

   always_comb begin
      logic [31:0] rad;
      logic [18:0] rem;
      logic [15:0] root;
      logic [18:0] trial;
      rad  = d.rad;
      rem  = d.rem;
      root = d.root;
      for (int k = 0; k < SqrtStepsPerStage; k++) begin
         rem   = {rem[16:0], rad[31:30]};
         rad   = {rad[29:0], 2'b00};
         trial = {1'b0, root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[14:0], 1'b1};
         end else begin
            root = {root[14:0], 1'b0};
         end
      end
      step_in.rad  = rad;
      step_in.rem  = rem;
      step_in.root = root;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         step_ff <= step_in;
      end
   end

   assign q = step_ff;

endmodule
`default_nettype wire

/* hw/rtl/lcwv_boost.sv */
// Vibrance factor, lightness and chroma scaling, and the output register.
`timescale 1ns / 1ps
`default_nettype none
module lcwv_boost (
   input  wire logic                  clock,
   input  wire logic [3:0]            stage_en,
   input  wire logic [15:0]           root,
   input  wire lcwv_pkg::payload_type pay,
   input  wire logic [6:0]            percent,
   input  wire logic [1:0]            channels,
   output logic [14:0]                out_lightness,
   output logic signed [15:0]         out_chroma_a,
   output logic signed [15:0]         out_chroma_b,
   output logic [15:0]                out_alpha,
   output logic                       out_last_pixel
);
   import lcwv_pkg::*;

   function automatic logic [15:0] sat_chroma(input logic neg, input logic [17:0] m);
      logic [17:0] nm;
      logic [15:0] r;
      nm = ~m + 18'd1;
      if (neg) begin
         r = (m > 18'd32768) ? 16'h8000 : nm[15:0];
      end else begin
         r = (m > 18'd32767) ? 16'h7FFF : m[15:0];
      end
      return r;
   endfunction

   // stage 6: percent times chroma weight
   logic [22:0] pm_in;
   logic [22:0] pm_ff;
   payload_type pay6_ff;

   // stage 7: reciprocal multiply for the divide by hundred
   logic [46:0] qp_in;
   logic [46:0] qp_ff;
   payload_type pay7_ff;

   // stage 8: factor applied to lightness and both chroma magnitudes
   logic [15:0] f16;
   logic [16:0] gain;
   logic [15:0] amag;
   logic [15:0] bmag;
   logic [30:0] lprod_in;
   logic [32:0] aprod_in;
   logic [32:0] bprod_in;
   logic [30:0] lprod_ff;
   logic [32:0] aprod_ff;
   logic [32:0] bprod_ff;
   payload_type pay8_ff;

   // stage 9: rounding, clamping and channel select
   logic [31:0] lsum;
   logic [13:0] ldec;
   logic [14:0] lnew;
   logic [33:0] asum;
   logic [33:0] bsum;
   logic [15:0] anew;
   logic [15:0] bnew;
   logic [14:0] lightness_in;
   logic [15:0] chroma_a_in;
   logic [15:0] chroma_b_in;
   logic [14:0] lightness_ff;
   logic [15:0] chroma_a_ff;
   logic [15:0] chroma_b_ff;
   logic [15:0] alpha_ff;
   logic        last_ff;

   assign pm_in = percent * root + RoundHalf;
   assign qp_in = pm_ff * RecipMul;

   assign f16      = qp_ff[RecipShift+15:RecipShift];
   assign gain     = {1'b0, f16} + 17'h10000;
   assign amag     = pay7_ff.chroma_a[15] ? (~pay7_ff.chroma_a + 16'd1) : pay7_ff.chroma_a;
   assign bmag     = pay7_ff.chroma_b[15] ? (~pay7_ff.chroma_b + 16'd1) : pay7_ff.chroma_b;
   assign lprod_in = pay7_ff.lightness * f16;
   assign aprod_in = amag * gain;
   assign bprod_in = bmag * gain;

   assign lsum = {1'b0, lprod_ff} + 32'h0002_0000;
   assign ldec = lsum[31:18];
   assign lnew = ({1'b0, ldec} >= pay8_ff.lightness) ? 15'd0
                                                     : pay8_ff.lightness - {1'b0, ldec};
   assign asum = {1'b0, aprod_ff} + 34'h0_0000_8000;
   assign bsum = {1'b0, bprod_ff} + 34'h0_0000_8000;
   assign anew = sat_chroma(pay8_ff.chroma_a[15], asum[33:16]);
   assign bnew = sat_chroma(pay8_ff.chroma_b[15], bsum[33:16]);

   always_comb begin
      lightness_in = pay8_ff.lightness;
      chroma_a_in  = pay8_ff.chroma_a;
      chroma_b_in  = pay8_ff.chroma_b;
      if (channels >= ChanLumaA) begin
         lightness_in = lnew;
         chroma_a_in  = anew;
         if (channels >= ChanAll) begin
            chroma_b_in = bnew;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pm_ff   <= pm_in;
         pay6_ff <= pay;
      end
      if (stage_en[1]) begin
         qp_ff   <= qp_in;
         pay7_ff <= pay6_ff;
      end
      if (stage_en[2]) begin
         lprod_ff <= lprod_in;
         aprod_ff <= aprod_in;
         bprod_ff <= bprod_in;
         pay8_ff  <= pay7_ff;
      end
      if (stage_en[3]) begin
         lightness_ff <= lightness_in;
         chroma_a_ff  <= chroma_a_in;
         chroma_b_ff  <= chroma_b_in;
         alpha_ff     <= pay8_ff.alpha;
         last_ff      <= pay8_ff.last_pixel;
      end
   end

   assign out_lightness  = lightness_ff;
   assign out_chroma_a   = chroma_a_ff;
   assign out_chroma_b   = chroma_b_ff;
   assign out_alpha      = alpha_ff;
   assign out_last_pixel = last_ff;

endmodule
`default_nettype wire

/* hw/rtl/lab_chroma_weighted_vibrance.sv */
// Top level of the Lab chroma-weighted vibrance pipeline.
//
// Ten-stage pipeline that takes one Lab pixel per clock while req_stall is low
// and returns one result per pixel, in order. The depth is set by the chroma
// magnitude square root, which resolves four root bits in each of four stages,
// and by the factor path (two multiplies for the percent divide, one for the
// scaling). Every stage has its own valid bit; rsp_stall holds only the stages
// that are full, so bubbles are squeezed out and req_stall rises only when the
// whole pipeline is occupied. Configuration writes take effect at once and are
// to be made while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module lab_chroma_weighted_vibrance (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [14:0]        req_lightness,
   input  wire logic signed [15:0] req_chroma_a,
   input  wire logic signed [15:0] req_chroma_b,
   input  wire logic [15:0]        req_alpha,
   input  wire logic               req_last_pixel,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [14:0]             rsp_out_lightness,
   output logic signed [15:0]      rsp_out_chroma_a,
   output logic signed [15:0]      rsp_out_chroma_b,
   output logic [15:0]             rsp_out_alpha,
   output logic                    rsp_out_last_pixel,
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic [6:0]         csr_wdata
);
   import lcwv_pkg::*;

   logic [6:0]            percent_ff;
   logic [6:0]            percent_in;
   logic [1:0]            channels_ff;
   logic [1:0]            channels_in;
   logic [StageCount-1:0] stage_en;
   logic [31:0]           sum_sq;
   sqrt_type              sq [SqrtStageCount+1];
   payload_type           pay_in [PayloadDepth];
   payload_type           pay_ff [PayloadDepth];

   always_comb begin
      percent_in  = percent_ff;
      channels_in = channels_ff;
      if (csr_write) begin
         case (csr_index)
            CsrPercent:  percent_in  = csr_wdata;
            CsrChannels: channels_in = csr_wdata[1:0];
            default: begin
               percent_in  = percent_ff;
               channels_in = channels_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         percent_ff  <= PercentReset;
         channels_ff <= ChannelsReset;
      end else begin
         percent_ff  <= percent_in;
         channels_ff <= channels_in;
      end
   end

   lcwv_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .stage_en  (stage_en)
   );

   always_comb begin
      pay_in[0].lightness  = req_lightness;
      pay_in[0].chroma_a   = req_chroma_a;
      pay_in[0].chroma_b   = req_chroma_b;
      pay_in[0].alpha      = req_alpha;
      pay_in[0].last_pixel = req_last_pixel;
      for (int i = 1; i < PayloadDepth; i++) begin
         pay_in[i] = pay_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PayloadDepth; i++) begin
         if (stage_en[i]) begin
            pay_ff[i] <= pay_in[i];
         end
      end
   end

   lcwv_front u_front (
      .clock    (clock),
      .stage_en (stage_en[FrontStageCount-1:0]),
      .chroma_a (req_chroma_a),
      .chroma_b (req_chroma_b),
      .sum_sq   (sum_sq)
   );

   assign sq[0].rad  = sum_sq;
   assign sq[0].rem  = '0;
   assign sq[0].root = '0;

   for (genvar g = 0; g < SqrtStageCount; g++) begin : g_sqrt
      lcwv_isqrt_stage u_stage (
         .clock (clock),
         .load  (stage_en[FrontStageCount+g]),
         .d     (sq[g]),
         .q     (sq[g+1])
      );
   end

   lcwv_boost u_boost (
      .clock          (clock),
      .stage_en       (stage_en[BoostFirst+BoostStageCount-1:BoostFirst]),
      .root           (sq[SqrtStageCount].root),
      .pay            (pay_ff[PayloadDepth-1]),
      .percent        (percent_ff),
      .channels       (channels_ff),
      .out_lightness  (rsp_out_lightness),
      .out_chroma_a   (rsp_out_chroma_a),
      .out_chroma_b   (rsp_out_chroma_b),
      .out_alpha      (rsp_out_alpha),
      .out_last_pixel (rsp_out_last_pixel)
   );

endmodule
`default_nettype wire

/* verif/vibrance_checker.sv */
// Checker for the vibrance pipeline: predicts each pixel and compares the results in order.
`timescale 1ns / 1ps
module vibrance_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [14:0] req_lightness,
   input  wire logic [15:0] req_chroma_a,
   input  wire logic [15:0] req_chroma_b,
   input  wire logic [15:0] req_alpha,
   input  wire logic        req_last_pixel,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [14:0] rsp_out_lightness,
   input  wire logic [15:0] rsp_out_chroma_a,
   input  wire logic [15:0] rsp_out_chroma_b,
   input  wire logic [15:0] rsp_out_alpha,
   input  wire logic        rsp_out_last_pixel,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wdata,
   output int               mismatches,
   output int               in_flight
);
   import lcwv_pkg::*;

   logic [6:0]  percent;
   logic [1:0]  channels;
   payload_type expected_pixels[$];
   int          results_seen;

   initial begin
      mismatches = 0;
      in_flight = 0;
      results_seen = 0;
      percent = PercentReset;
      channels = ChannelsReset;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("pixel %0d: %s got %0d, expected %0d", results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic longint floor_root(input longint value);
      longint rest, root, step;
      rest = value;
      root = 0;
      step = longint'(1) << 62;
      while (step > rest)
         step >>= 2;
      while (step != 0) begin
         if (rest >= root + step) begin
            rest -= root + step;
            root = (root >> 1) + step;
         end else begin
            root >>= 1;
         end
         step >>= 2;
      end
      return root;
   endfunction

   // round half away from zero, then saturate to Q15.0 (signed 16-bit integer)
   function automatic logic [15:0] boost_chroma(input logic [15:0] c, input longint gain);
      longint value, m;
      value = longint'($signed(c));
      m = (((value < 0) ? -value : value) * gain + 32768) >> 16;
      if (value < 0)
         return (m > 32768) ? 16'h8000 : 16'(-m);
      return (m > 32767) ? 16'h7FFF : 16'(m);
   endfunction

   function automatic payload_type vibrance_pixel(input payload_type px);
      payload_type res;
      longint a, b, root, f16, lval, dec, gain;
      res = px;
      if (channels >= ChanLumaA) begin
         a = longint'($signed(px.chroma_a));
         b = longint'($signed(px.chroma_b));
         root = floor_root(a * a + b * b);
         f16 = (longint'(percent) * root + 50) / 100;
         lval = longint'(px.lightness);
         dec = (lval * f16 + (longint'(1) << 17)) >> 18;
         res.lightness = (dec >= lval) ? 15'd0 : 15'(lval - dec);
         gain = 65536 + f16;
         res.chroma_a = boost_chroma(px.chroma_a, gain);
         if (channels == ChanAll)
            res.chroma_b = boost_chroma(px.chroma_b, gain);
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      payload_type got, want, in_px;
      if (reset) begin
         percent <= PercentReset;
         channels <= ChannelsReset;
         expected_pixels.delete();
         in_flight <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CsrPercent)
               percent <= csr_wdata;
            else
               channels <= csr_wdata[1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            got.lightness = rsp_out_lightness;
            got.chroma_a = rsp_out_chroma_a;
            got.chroma_b = rsp_out_chroma_b;
            got.alpha = rsp_out_alpha;
            got.last_pixel = rsp_out_last_pixel;
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected item, lightness", got.lightness, -1);
            end else begin
               want = expected_pixels.pop_front();
               if (got.lightness !== want.lightness)
                  report_mismatch("lightness", got.lightness, want.lightness);
               if (got.chroma_a !== want.chroma_a)
                  report_mismatch("chroma a", $signed(got.chroma_a), $signed(want.chroma_a));
               if (got.chroma_b !== want.chroma_b)
                  report_mismatch("chroma b", $signed(got.chroma_b), $signed(want.chroma_b));
               if (got.alpha !== want.alpha)
                  report_mismatch("alpha", got.alpha, want.alpha);
               if (got.last_pixel !== want.last_pixel)
                  report_mismatch("last pixel", got.last_pixel, want.last_pixel);
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            in_px.lightness = req_lightness;
            in_px.chroma_a = req_chroma_a;
            in_px.chroma_b = req_chroma_b;
            in_px.alpha = req_alpha;
            in_px.last_pixel = req_last_pixel;
            expected_pixels.push_back(vibrance_pixel(in_px));
         end
         in_flight <= expected_pixels.size();
      end
   end

endmodule

/* verif/testbench.sv */
// Top of the vibrance testbench: clock, reset, pixel stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
   import lcwv_pkg::*;

   localparam logic [1:0] ChanNone = 2'd0;
   localparam logic [1:0] ChanOne  = 2'd1;
   localparam int RandomItems   = 1930;
   localparam int HoldCycles    = 400;
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 2 * StageCount;

   typedef enum int {RxReady, RxRandom, RxBursty} rx_mode_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [14:0] req_lightness = '0;
   logic [15:0] req_chroma_a = '0;
   logic [15:0] req_chroma_b = '0;
   logic [15:0] req_alpha = '0;
   logic        req_last_pixel = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_out_lightness;
   logic [15:0] rsp_out_chroma_a;
   logic [15:0] rsp_out_chroma_b;
   logic [15:0] rsp_out_alpha;
   logic        rsp_out_last_pixel;
   logic        csr_write = 1'b0;
   logic        csr_index = CsrPercent;
   logic [6:0]  csr_wdata = '0;

   int   mismatches;
   int   in_flight;
   int   stalled_cycles = 0;
   logic want_hold = 1'b0;
   logic sender_quiet = 1'b0;

   lab_chroma_weighted_vibrance DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_lightness      (req_lightness),
      .req_chroma_a       (req_chroma_a),
      .req_chroma_b       (req_chroma_b),
      .req_alpha          (req_alpha),
      .req_last_pixel     (req_last_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_lightness  (rsp_out_lightness),
      .rsp_out_chroma_a   (rsp_out_chroma_a),
      .rsp_out_chroma_b   (rsp_out_chroma_b),
      .rsp_out_alpha      (rsp_out_alpha),
      .rsp_out_last_pixel (rsp_out_last_pixel),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   vibrance_checker pixel_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_lightness      (req_lightness),
      .req_chroma_a       (req_chroma_a),
      .req_chroma_b       (req_chroma_b),
      .req_alpha          (req_alpha),
      .req_last_pixel     (req_last_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_lightness  (rsp_out_lightness),
      .rsp_out_chroma_a   (rsp_out_chroma_a),
      .rsp_out_chroma_b   (rsp_out_chroma_b),
      .rsp_out_alpha      (rsp_out_alpha),
      .rsp_out_last_pixel (rsp_out_last_pixel),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .in_flight          (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic payload_type pixel(input logic [14:0] l, input logic [15:0] a,
                                         input logic [15:0] b, input logic [15:0] alpha,
                                         input logic last);
      payload_type px;
      px.lightness = l;
      px.chroma_a = a;
      px.chroma_b = b;
      px.alpha = alpha;
      px.last_pixel = last;
      return px;
   endfunction

   function automatic logic [15:0] random_chroma();
      int m;
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 1023)) - 16'd512;
         1: return 16'($urandom);
         2: begin
            m = $urandom_range(24000, 32768);
            return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
         end
         default: return 16'($urandom_range(0, 16383)) - 16'd8192;
      endcase
   endfunction

   function automatic payload_type random_pixel(input logic last);
      logic [14:0] l;
      l = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(0, 25600)) : 15'($urandom);
      return pixel(l, random_chroma(), random_chroma(), 16'($urandom), last);
   endfunction

   // returns at the edge where the item is taken
   task automatic offer(input payload_type px);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lightness <= px.lightness;
      req_chroma_a <= px.chroma_a;
      req_chroma_b <= px.chroma_b;
      req_alpha <= px.alpha;
      req_last_pixel <= px.last_pixel;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_settings(input logic [6:0] pct, input logic [1:0] chans);
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      csr_write <= 1'b1;
      csr_index <= CsrPercent;
      csr_wdata <= pct;
      @(posedge clock);
      csr_index <= CsrChannels;
      csr_wdata <= {5'd0, chans};
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin : receiver
      rx_mode_type mode;
      int run, busy_left;
      busy_left = 0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 2));
         run = $urandom_range(30, 300);
         repeat (run) begin
            @(posedge clock);
            if (want_hold) begin
               // long hold-off so the pipeline fills and pushes back on the sender
               want_hold = 1'b0;
               rsp_stall <= 1'b1;
               repeat (HoldCycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end else if (mode == RxReady) begin
               rsp_stall <= 1'b0;
            end else if (mode == RxRandom) begin
               rsp_stall <= ($urandom_range(0, 99) < 40);
            end else if (busy_left > 0) begin
               busy_left--;
               rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < 15) begin
               busy_left = pick_gap();
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase, count, i, n, region_left, r;
      logic [6:0] pct;
      logic [1:0] chans;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero chroma, full-scale chroma, lightness beyond 100
      offer(pixel(15'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      offer(pixel(15'd25600, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0));
      offer(pixel(15'h7FFF, 16'h8000, 16'h8000, 16'h0000, 1'b1));
      offer(pixel(15'd12800, 16'h0100, 16'hFF00, 16'h5A5A, 1'b0));
      offer(pixel(15'd100, 16'h8000, 16'h7FFF, 16'hA5A5, 1'b1));

      // percent above hundred, chroma saturation on both signs
      write_settings(7'd127, ChanAll);
      offer(pixel(15'd25600, 16'h7FFF, 16'h0000, 16'h1234, 1'b0));
      offer(pixel(15'd25600, 16'h8000, 16'h0000, 16'h4321, 1'b0));
      offer(pixel(15'd1, 16'd30000, -16'sd30000, 16'hFFFF, 1'b0));
      offer(pixel(15'h7FFF, 16'hFFFF, 16'h0001, 16'h0000, 1'b0));
      offer(pixel(15'd0, 16'd20000, 16'd20000, 16'h8001, 1'b1));

      // two channels: b passes through
      write_settings(7'd100, ChanLumaA);
      offer(pixel(15'd20000, 16'd30000, -16'sd30000, 16'h00FF, 1'b0));
      offer(pixel(15'd500, -16'sd20000, 16'd12345, 16'hFF00, 1'b0));
      offer(pixel(15'd25600, 16'h0000, 16'h8000, 16'h7777, 1'b1));

      // one channel and zero channels: whole pixel passes through
      write_settings(7'd50, ChanOne);
      offer(pixel(15'h7FFF, 16'h8000, 16'h7FFF, 16'hBEEF, 1'b0));
      offer(pixel(15'd9000, 16'd25000, -16'sd25000, 16'h0F0F, 1'b1));
      write_settings(7'd75, ChanNone);
      offer(pixel(15'd25600, 16'h7FFF, 16'h8000, 16'hF0F0, 1'b0));
      offer(pixel(15'd3, -16'sd3, 16'd3, 16'h0001, 1'b1));

      // zero strength, then full strength
      write_settings(7'd0, ChanAll);
      offer(pixel(15'd25600, 16'h8000, 16'h7FFF, 16'hCAFE, 1'b0));
      offer(pixel(15'd7000, 16'd1000, -16'sd1000, 16'h3C3C, 1'b1));
      write_settings(7'd100, ChanAll);
      offer(pixel(15'd25600, 16'h8000, 16'h8000, 16'hC3C3, 1'b0));
      offer(pixel(15'd18000, 16'd1, 16'hFFFF, 16'h6666, 1'b1));

      count = 0;
      phase = 0;
      region_left = $urandom_range(1, 64);
      while (count < RandomItems) begin
         r = $urandom_range(0, 9);
         case (r)
            0: pct = 7'd0;
            1: pct = 7'd100;
            2: pct = 7'd127;
            3: pct = 7'($urandom_range(101, 127));
            default: pct = 7'($urandom_range(0, 100));
         endcase
         r = $urandom_range(0, 9);
         case (r)
            0: chans = ChanNone;
            1: chans = ChanOne;
            2, 3: chans = ChanLumaA;
            default: chans = ChanAll;
         endcase
         write_settings(pct, chans);
         sender_quiet = ($urandom_range(0, 3) == 0);
         n = $urandom_range(60, 250);
         for (i = 0; i < n && count < RandomItems; i++) begin
            if (phase % 4 == 1 && i == 20)
               want_hold = 1'b1;
            region_left--;
            offer(random_pixel(region_left == 0));
            if (region_left == 0)
               region_left = $urandom_range(1, 64);
            count++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
